/* design/qrs_pkg.sv */
// qrs_pkg: shared types and constants of the quadratic root solver
// no dependencies
`default_nettype none

package qrs_pkg;

  // root count codes
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  localparam int COEF_W = 32;
  localparam int TOL_W  = 16;
  localparam int DISC_W = 66;   // discriminant magnitude, below 2^66
  localparam int ROOT_W = 33;   // floor square root of the discriminant
  localparam int NUM_W  = 35;   // signed numerator -b +/- s
  localparam int DEN_W  = 34;   // signed denominator, 2a or b

  // control that travels beside the square root
  typedef struct packed {
    logic [1:0]               count;
    logic                     need_s;
    logic signed [DEN_W-1:0]  num;
    logic signed [DEN_W-1:0]  den;
  } front_t;

  // one result word
  typedef struct packed {
    logic [1:0]               count;
    logic [COEF_W-1:0]        first;
    logic [COEF_W-1:0]        second;
    logic                     sat;
  } res_t;

endpackage

`default_nettype wire

/* design/qrs_ifs.sv */
// qrs_ifs: handshake channels of the quadratic root solver
// depends on nothing but plain logic types
`default_nettype none

interface qrs_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coef_a;
  logic signed [31:0] coef_b;
  logic signed [31:0] coef_c;
  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         root_count;
  logic signed [31:0] root_first;
  logic signed [31:0] root_second;
  logic               saturated;
  modport source (output valid, root_count, root_first, root_second, saturated,
                  input ready);
  modport sink (input valid, root_count, root_first, root_second, saturated,
                output ready);
endinterface

interface qrs_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] zero_tolerance;
  modport source (output valid, zero_tolerance, input ready);
  modport sink (input valid, zero_tolerance, output ready);
endinterface

`default_nettype wire

/* design/qrs_sqrt.sv */
// qrs_sqrt: pipelined restoring square root, one result bit per stage
// depends on qrs_pkg
`default_nettype none

module qrs_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [qrs_pkg::DISC_W-1:0] in_rad,
  input  wire qrs_pkg::front_t            in_ctl,
  output logic                            out_valid,
  output logic [qrs_pkg::ROOT_W-1:0]      out_root,
  output qrs_pkg::front_t                 out_ctl
);
  import qrs_pkg::*;

  localparam int STEPS = ROOT_W;
  localparam int RW    = DISC_W + 2;

  logic [STEPS-1:0]  v_r;
  logic [RW-1:0]     rem_r  [STEPS];
  logic [ROOT_W-1:0] root_r [STEPS];
  front_t            ctl_r  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int B = STEPS - 1 - k;
    logic              v_prev;
    logic [RW-1:0]     rem_prev;
    logic [ROOT_W-1:0] root_prev;
    front_t            ctl_prev;
    logic [RW-1:0]     trial;
    logic              ge;
    logic [RW-1:0]     rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (k == 0) begin : g_first
      assign v_prev    = in_valid;
      assign rem_prev  = RW'(in_rad);
      assign root_prev = '0;
      assign ctl_prev  = in_ctl;
    end else begin : g_rest
      assign v_prev    = v_r[k-1];
      assign rem_prev  = rem_r[k-1];
      assign root_prev = root_r[k-1];
      assign ctl_prev  = ctl_r[k-1];
    end

    // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
    always_comb begin
      trial    = (RW'(root_prev) << (B + 1)) | (RW'(1) << (2 * B));
      ge       = rem_prev >= trial;
      rem_nxt  = ge ? rem_prev - trial : rem_prev;
      root_nxt = ge ? (root_prev | (ROOT_W'(1) << B)) : root_prev;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        ctl_r[k]  <= ctl_prev;
      end
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign out_root  = root_r[STEPS-1];
  assign out_ctl   = ctl_r[STEPS-1];

endmodule

`default_nettype wire

/* design/qrs_div.sv */
// qrs_div: two-lane pipelined fixed-point divider with clamping
// depends on qrs_pkg
`default_nettype none

module qrs_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             en,
  input  wire logic                             in_valid,
  input  wire logic [1:0]                       in_count,
  input  wire logic signed [qrs_pkg::NUM_W-1:0] in_num1,
  input  wire logic signed [qrs_pkg::NUM_W-1:0] in_num2,
  input  wire logic signed [qrs_pkg::DEN_W-1:0] in_den,
  output logic                                  out_valid,
  output logic [1:0]                            out_count,
  output logic [qrs_pkg::COEF_W-1:0]            out_q1,
  output logic [qrs_pkg::COEF_W-1:0]            out_q2,
  output logic                                  out_sat1,
  output logic                                  out_sat2
);
  import qrs_pkg::*;

  localparam int QB    = 33;                   // quotient bits kept
  localparam int MAG_W = DEN_W - 1;            // divisor magnitude
  localparam int CW    = DISC_W + FRAC_BITS;   // remainder and compare width
  localparam int LAST  = QB;

  typedef struct packed {
    logic [CW-1:0]    rem;
    logic [QB-1:0]    q;
    logic [MAG_W-1:0] dm;
    logic             neg;
    logic             ovf;
  } lane_t;

  logic [LAST:0] v_r;
  logic [1:0]    cnt_r [LAST+1];
  lane_t         st_r  [LAST+1][2];

  // precheck stage: magnitudes, sign and quotient overflow
  logic signed [NUM_W-1:0] num_in [2];
  assign num_in[0] = in_num1;
  assign num_in[1] = in_num2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cnt_r[0] <= in_count;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_pre
    logic [NUM_W-1:0] nmag;
    logic [DEN_W-1:0] dmag;
    logic [CW-1:0]    nsh;
    lane_t            pre_nxt;

    always_comb begin
      nmag = num_in[l][NUM_W-1] ? NUM_W'(-num_in[l]) : NUM_W'(num_in[l]);
      dmag = in_den[DEN_W-1] ? DEN_W'(-in_den) : DEN_W'(in_den);
      nsh  = CW'(nmag) << FRAC_BITS;
      pre_nxt.rem = nsh;
      pre_nxt.q   = '0;
      pre_nxt.dm  = dmag[MAG_W-1:0];
      pre_nxt.neg = num_in[l][NUM_W-1] ^ in_den[DEN_W-1];
      pre_nxt.ovf = nsh >= (CW'(dmag[MAG_W-1:0]) << QB);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[0][l] <= pre_nxt;
      end
    end
  end

  // long division, one quotient bit per stage
  for (genvar k = 1; k <= LAST; k++) begin : g_step
    localparam int B = QB - k;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cnt_r[k] <= cnt_r[k-1];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [CW-1:0] sub;
      logic          ge;
      lane_t         st_nxt;

      always_comb begin
        sub    = CW'(st_r[k-1][l].dm) << B;
        ge     = st_r[k-1][l].rem >= sub;
        st_nxt = st_r[k-1][l];
        if (ge) begin
          st_nxt.rem = st_r[k-1][l].rem - sub;
          st_nxt.q   = st_r[k-1][l].q | (QB'(1) << B);
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          st_r[k][l] <= st_nxt;
        end
      end
    end
  end

  // clamp to the signed 32-bit range
  logic [COEF_W-1:0] qv  [2];
  logic              sat [2];

  for (genvar l = 0; l < 2; l++) begin : g_clamp
    always_comb begin
      if (!st_r[LAST][l].neg) begin
        sat[l] = st_r[LAST][l].ovf || (st_r[LAST][l].q > QB'(33'h0_7FFF_FFFF));
        qv[l]  = sat[l] ? 32'h7FFF_FFFF : st_r[LAST][l].q[COEF_W-1:0];
      end else begin
        sat[l] = st_r[LAST][l].ovf || (st_r[LAST][l].q > QB'(33'h0_8000_0000));
        qv[l]  = sat[l] ? 32'h8000_0000 : COEF_W'(-st_r[LAST][l].q[COEF_W-1:0]);
      end
    end
  end

  assign out_valid = v_r[LAST];
  assign out_count = cnt_r[LAST];
  assign out_q1    = qv[0];
  assign out_q2    = qv[1];
  assign out_sat1  = sat[0];
  assign out_sat2  = sat[1];

endmodule

`default_nettype wire

/* design/quadratic_root_solver.sv */
// quadratic_root_solver: top level, front end, root assembly and output stage
// depends on qrs_pkg, qrs_ifs, qrs_sqrt and qrs_div
//
// usage
//   in_word   : coefficient word (coef_a, coef_b, coef_c), signed fixed point
//   out_word  : result word (root_count, root_first, root_second, saturated)
//   cfg_word  : zero_tolerance write, always ready; write only while idle
// latency: 72 register stages, out_word.valid rises 71 cycles after the
//   accepting edge, so the result can be taken 72 cycles after its in_word
//   input register, magnitudes and products, discriminant, 33 square root
//   stages, numerator stage, overflow precheck, 33 divider stages, output
//   register; the root and quotient pipelines take one bit per stage
// throughput: one word per cycle, every stage is a register stage
// reset: all valid bits clear, zero_tolerance returns to 1
// stall: when out_word is not taken the next result parks in a one-word skid
//   register; the pipeline freezes only once the skid is full, so in_word
//   keeps being taken while a finished result waits
`default_nettype none

module quadratic_root_solver #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  qrs_in_if.sink     in_word,
  qrs_out_if.source  out_word,
  qrs_cfg_if.sink    cfg_word
);
  import qrs_pkg::*;

  // tolerance register, zero acts as one
  logic [TOL_W-1:0] tol_r;
  logic [TOL_W-1:0] tol;

  assign cfg_word.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_W'(1);
    end else if (cfg_word.valid) begin
      tol_r <= cfg_word.zero_tolerance;
    end
  end

  assign tol = (tol_r == '0) ? TOL_W'(1) : tol_r;

  // pipeline advances while the skid register is empty
  logic en;
  logic skid_valid_r;
  assign en            = !skid_valid_r;
  assign in_word.ready = en;

  // stage 1: input register
  logic                     s1_v_r;
  logic signed [COEF_W-1:0] s1_a_r, s1_b_r, s1_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r <= in_word.coef_a;
      s1_b_r <= in_word.coef_b;
      s1_c_r <= in_word.coef_c;
    end
  end

  // stage 2: magnitudes, zero tests and the two products
  logic [COEF_W-1:0]        am, bm, cm;
  logic                     s2_v_r;
  logic                     s2_az_r, s2_bz_r, s2_cz_r, s2_xs_r;
  logic [2*COEF_W-1:0]      s2_bb_r, s2_p_r;
  logic signed [COEF_W-1:0] s2_a_r, s2_b_r, s2_c_r;

  always_comb begin
    am = s1_a_r[COEF_W-1] ? COEF_W'(-s1_a_r) : COEF_W'(s1_a_r);
    bm = s1_b_r[COEF_W-1] ? COEF_W'(-s1_b_r) : COEF_W'(s1_b_r);
    cm = s1_c_r[COEF_W-1] ? COEF_W'(-s1_c_r) : COEF_W'(s1_c_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_az_r <= am < COEF_W'(tol);
      s2_bz_r <= bm < COEF_W'(tol);
      s2_cz_r <= cm < COEF_W'(tol);
      s2_xs_r <= s1_a_r[COEF_W-1] ^ s1_c_r[COEF_W-1];
      s2_bb_r <= bm * bm;
      s2_p_r  <= am * cm;
      s2_a_r  <= s1_a_r;
      s2_b_r  <= s1_b_r;
      s2_c_r  <= s1_c_r;
    end
  end

  // stage 3: discriminant and case selection
  logic [DISC_W-1:0] p4, bbw, disc;
  logic              dneg, dz;
  front_t            front;
  logic              s3_v_r;
  logic [DISC_W-1:0] s3_disc_r;
  front_t            s3_ctl_r;

  always_comb begin
    p4   = {s2_p_r, 2'b00};
    bbw  = DISC_W'(s2_bb_r);
    dneg = 1'b0;
    if (s2_xs_r) begin
      disc = bbw + p4;
    end else begin
      dneg = p4 > bbw;
      disc = bbw - p4;
    end
    dz = disc < DISC_W'(tol);

    front.need_s = 1'b0;
    front.num    = -DEN_W'(s2_b_r);
    front.den    = DEN_W'(s2_a_r) <<< 1;
    if (s2_az_r) begin
      // linear equation b x + c = 0
      if (s2_bz_r) begin
        front.count = s2_cz_r ? CNT_INF : CNT_NONE;
        front.den   = DEN_W'(1);
      end else begin
        front.count = CNT_ONE;
        front.num   = -DEN_W'(s2_c_r);
        front.den   = DEN_W'(s2_b_r);
      end
    end else if (dneg) begin
      front.count = CNT_NONE;
    end else if (dz) begin
      front.count = CNT_ONE;
    end else begin
      front.count  = CNT_TWO;
      front.need_s = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_disc_r <= disc;
      s3_ctl_r  <= front;
    end
  end

  // square root of the discriminant
  logic              sq_v;
  logic [ROOT_W-1:0] sq_root;
  front_t            sq_ctl;

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_v_r),
    .in_rad    (s3_disc_r),
    .in_ctl    (s3_ctl_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_ctl   (sq_ctl)
  );

  // numerator stage: -b + s and -b - s, or the single numerator
  logic signed [NUM_W-1:0] s_ext, n1_nxt, n2_nxt;
  logic                    s4_v_r;
  logic [1:0]              s4_cnt_r;
  logic signed [NUM_W-1:0] s4_n1_r, s4_n2_r;
  logic signed [DEN_W-1:0] s4_den_r;

  always_comb begin
    s_ext  = $signed({2'b00, sq_root});
    n1_nxt = NUM_W'(sq_ctl.num) + (sq_ctl.need_s ? s_ext : NUM_W'(0));
    n2_nxt = NUM_W'(sq_ctl.num) - s_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_cnt_r <= sq_ctl.count;
      s4_n1_r  <= n1_nxt;
      s4_n2_r  <= n2_nxt;
      s4_den_r <= sq_ctl.den;
    end
  end

  // two quotients in parallel lanes
  logic              dv_v, dv_sat1, dv_sat2;
  logic [1:0]        dv_cnt;
  logic [COEF_W-1:0] dv_q1, dv_q2;

  qrs_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s4_v_r),
    .in_count  (s4_cnt_r),
    .in_num1   (s4_n1_r),
    .in_num2   (s4_n2_r),
    .in_den    (s4_den_r),
    .out_valid (dv_v),
    .out_count (dv_cnt),
    .out_q1    (dv_q1),
    .out_q2    (dv_q2),
    .out_sat1  (dv_sat1),
    .out_sat2  (dv_sat2)
  );

  // root assembly: unset roots read as zero
  res_t res;
  logic has1, has2;

  always_comb begin
    has1       = (dv_cnt == CNT_ONE) || (dv_cnt == CNT_TWO);
    has2       = dv_cnt == CNT_TWO;
    res.count  = dv_cnt;
    res.first  = has1 ? dv_q1 : '0;
    res.second = has2 ? dv_q2 : '0;
    res.sat    = (has1 && dv_sat1) || (has2 && dv_sat2);
  end

  // output register with one-word skid
  logic out_valid_r;
  res_t out_data_r, skid_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_word.ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= dv_v;
      end
    end else if (dv_v && !skid_valid_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_word.ready || !out_valid_r) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (!skid_valid_r) begin
      skid_data_r <= res;
    end
  end

  assign out_word.valid       = out_valid_r;
  assign out_word.root_count  = out_data_r.count;
  assign out_word.root_first  = out_data_r.first;
  assign out_word.root_second = out_data_r.second;
  assign out_word.saturated   = out_data_r.sat;

endmodule

`default_nettype wire
